>>> rtl/core/response_defect_injector_core_defines.svh
// Assertion macros used by the core file response_defect_injector_core.sv.
`ifndef RESPONSE_DEFECT_INJECTOR_CORE_DEFINES_SVH
`define RESPONSE_DEFECT_INJECTOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RDI_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("rdi: invariant violated");
`define RDI_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdi: implication violated");
`else
`define RDI_ASSERT_ALWAYS(label, clk, rst, cond)
`define RDI_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/rdi_pkg.sv
package rdi_pkg;

   localparam int SLOT_COUNT_DEFAULT = 64;
   localparam int BLOCK_REGS = 16;
   localparam int BYTE_INDEX_W = 6;
   localparam int SLOT_WORD_W = 19;

   localparam logic [BYTE_INDEX_W-1:0] DATA_END = BYTE_INDEX_W'(2 * BLOCK_REGS);
   localparam logic [BYTE_INDEX_W-1:0] FRAME_LAST = BYTE_INDEX_W'(2 * BLOCK_REGS + 1);

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hDEAD;
   localparam logic [8:0] MAX_X = 9'd319;
   localparam logic [7:0] MAX_Y = 8'd79;
   localparam logic [3:0] FULL_BLOCK_COUNT = 4'hF;

   localparam logic [7:0] POS_BASE_FIRST = 8'h70;
   localparam logic [7:0] POS_BASE_LAST = 8'hA0;
   localparam logic [7:0] STAT_BASE_FIRST = 8'hB0;
   localparam logic [7:0] STAT_BASE_LAST = 8'hE0;

   localparam logic [1:0] CMD_HEADER = 2'd0;
   localparam logic [1:0] CMD_BYTE = 2'd1;
   localparam logic [1:0] CMD_WRITE_SLOT = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
      logic [7:0] hctrl;
      logic [7:0] hadr;
      logic [5:0] slot;
      logic [8:0] pos_x;
      logic [7:0] pos_y;
      logic [2:0] status;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic byte_replaced;
      logic frame_end;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_HEADER,
      OP_PASS,
      OP_DATA,
      OP_CRC
   } op_type;

   typedef struct packed {
      op_type op;
      logic subst;
      logic lo_sel;
      logic is_status;
      logic crc_hi;
      logic frame_end;
      logic [7:0] data_byte;
      logic [7:0] hadr;
      logic [15:0] crc_seed;
   } stage_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/core/rdi_ram.sv
module rdi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/rdi_rewrite.sv
module rdi_rewrite (
   input  rdi_pkg::stage_type                  stage,
   input  logic [rdi_pkg::SLOT_WORD_W-1:0]     slot_word,
   input  logic [15:0]                         crc_cur,
   output rdi_pkg::rsp_type                    result,
   output logic                                emit,
   output logic [15:0]                         crc_next
);

   logic [15:0] word;

   always_comb begin
      word = stage.is_status ? {13'd0, slot_word[18:16]} : slot_word[15:0];
      result.out_byte = stage.data_byte;
      result.byte_replaced = 1'b0;
      result.frame_end = 1'b0;
      emit = 1'b0;
      crc_next = crc_cur;
      case (stage.op)
         rdi_pkg::OP_HEADER: begin
            crc_next = rdi_pkg::crc_byte(stage.crc_seed, stage.hadr);
         end
         rdi_pkg::OP_PASS: begin
            emit = 1'b1;
         end
         rdi_pkg::OP_DATA: begin
            emit = 1'b1;
            if (stage.subst) begin
               result.out_byte = stage.lo_sel ? word[7:0] : word[15:8];
               result.byte_replaced = 1'b1;
            end
            crc_next = rdi_pkg::crc_byte(crc_cur, result.out_byte);
         end
         rdi_pkg::OP_CRC: begin
            emit = 1'b1;
            result.frame_end = stage.frame_end;
            if (stage.subst) begin
               result.out_byte = stage.crc_hi ? crc_cur[15:8] : crc_cur[7:0];
               result.byte_replaced = 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/core/response_defect_injector_core.sv
// A response beat is registered in stage s1 and then in the output register for rsp.
// Throughput: one beat per cycle while rsp is not stalled; the slot word memory
// is read in the accept cycle and the CRC register is updated when s1 moves on.
// Reset is synchronous and active high; it clears the present bits, the frame
// state, the CRC and the enable register, and the block accepts beats at once.
`include "response_defect_injector_core_defines.svh"

module response_defect_injector_core #(
   parameter int SLOT_COUNT = rdi_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  rdi_pkg::req_type req_beat,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rdi_pkg::rsp_type rsp_beat
);

   localparam int AW = $clog2(SLOT_COUNT);

   logic inject_enable_ff;
   logic [SLOT_COUNT-1:0] present_ff, present_in;
   logic [rdi_pkg::BYTE_INDEX_W-1:0] byte_index_ff, byte_index_in;
   logic frame_active_ff, frame_active_in;
   logic frame_targeted_ff, frame_targeted_in;
   logic [5:0] block_base_ff, block_base_in;
   logic block_is_status_ff, block_is_status_in;
   logic [15:0] crc_ff;
   logic s1_valid_ff, s1_valid_in;
   rdi_pkg::stage_type s1_ff, s1_in;
   logic rsp_valid_ff, rsp_valid_in;
   rdi_pkg::rsp_type rsp_ff, rsp_in;

   logic out_free, accept, s1_move;
   logic [AW-1:0] rd_addr;
   logic [rdi_pkg::SLOT_WORD_W-1:0] wr_word, slot_word;
   logic [8:0] x_clamped;
   logic [7:0] y_clamped;
   logic hdr_qual, pos_hit, stat_hit, block_any;
   logic [5:0] hdr_base;
   rdi_pkg::rsp_type result;
   logic emit;
   logic [15:0] crc_next;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept = req_valid && !req_stall;
   assign s1_move = s1_valid_ff && out_free;

   assign x_clamped = (req_beat.pos_x > rdi_pkg::MAX_X) ? rdi_pkg::MAX_X : req_beat.pos_x;
   assign y_clamped = (req_beat.pos_y > rdi_pkg::MAX_Y) ? rdi_pkg::MAX_Y : req_beat.pos_y;
   assign wr_word = {req_beat.status, y_clamped[6:0], x_clamped};
   assign rd_addr = AW'(block_base_ff) + AW'(byte_index_ff[rdi_pkg::BYTE_INDEX_W-1:1]);

   assign hdr_qual = req_beat.hctrl[7] && (req_beat.hctrl[4:1] == rdi_pkg::FULL_BLOCK_COUNT);
   assign pos_hit = (req_beat.hadr[3:0] == 4'd0) && (req_beat.hadr >= rdi_pkg::POS_BASE_FIRST)
      && (req_beat.hadr <= rdi_pkg::POS_BASE_LAST);
   assign stat_hit = (req_beat.hadr[3:0] == 4'd0) && (req_beat.hadr >= rdi_pkg::STAT_BASE_FIRST)
      && (req_beat.hadr <= rdi_pkg::STAT_BASE_LAST);
   assign hdr_base = stat_hit ? 6'(req_beat.hadr - rdi_pkg::STAT_BASE_FIRST)
                              : 6'(req_beat.hadr - rdi_pkg::POS_BASE_FIRST);
   assign block_any = |present_ff[AW'(hdr_base) +: rdi_pkg::BLOCK_REGS];

   rdi_ram #(
      .WIDTH(rdi_pkg::SLOT_WORD_W),
      .DEPTH(SLOT_COUNT)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (accept && (req_beat.cmd == rdi_pkg::CMD_WRITE_SLOT)),
      .wr_addr(AW'(req_beat.slot)),
      .wr_data(wr_word),
      .rd_en  (accept && (req_beat.cmd == rdi_pkg::CMD_BYTE)),
      .rd_addr(rd_addr),
      .rd_data(slot_word)
   );

   always_comb begin
      present_in = present_ff;
      byte_index_in = byte_index_ff;
      frame_active_in = frame_active_ff;
      frame_targeted_in = frame_targeted_ff;
      block_base_in = block_base_ff;
      block_is_status_in = block_is_status_ff;
      s1_in = s1_ff;
      s1_in.op = rdi_pkg::OP_NONE;
      s1_in.subst = 1'b0;
      s1_in.lo_sel = byte_index_ff[0];
      s1_in.is_status = block_is_status_ff;
      s1_in.crc_hi = (byte_index_ff == rdi_pkg::DATA_END);
      s1_in.frame_end = 1'b0;
      s1_in.data_byte = req_beat.data_byte;
      s1_in.hadr = req_beat.hadr;
      s1_in.crc_seed = rdi_pkg::crc_byte(rdi_pkg::CRC_INIT, req_beat.hctrl);
      unique case (req_beat.cmd)
         rdi_pkg::CMD_HEADER: begin
            byte_index_in = '0;
            frame_active_in = hdr_qual;
            frame_targeted_in = hdr_qual && (pos_hit || stat_hit) && block_any;
            block_base_in = frame_targeted_in ? hdr_base : 6'd0;
            block_is_status_in = frame_targeted_in && stat_hit;
            s1_in.op = hdr_qual ? rdi_pkg::OP_HEADER : rdi_pkg::OP_NONE;
         end
         rdi_pkg::CMD_BYTE: begin
            s1_in.op = rdi_pkg::OP_PASS;
            if (inject_enable_ff && frame_active_ff) begin
               byte_index_in = byte_index_ff + 1'b1;
               if (byte_index_ff < rdi_pkg::DATA_END) begin
                  s1_in.op = rdi_pkg::OP_DATA;
                  s1_in.subst = frame_targeted_ff && present_ff[rd_addr];
               end else begin
                  s1_in.op = rdi_pkg::OP_CRC;
                  s1_in.subst = frame_targeted_ff;
                  if (byte_index_ff == rdi_pkg::FRAME_LAST) begin
                     s1_in.frame_end = 1'b1;
                     byte_index_in = '0;
                     frame_active_in = 1'b0;
                     frame_targeted_in = 1'b0;
                  end
               end
            end
         end
         rdi_pkg::CMD_WRITE_SLOT: begin
            present_in[AW'(req_beat.slot)] = 1'b1;
         end
         rdi_pkg::CMD_CLEAR: begin
            present_in = '0;
         end
         default: begin
            present_in = present_ff;
         end
      endcase
   end

   rdi_rewrite u_rewrite (
      .stage    (s1_ff),
      .slot_word(slot_word),
      .crc_cur  (crc_ff),
      .result   (result),
      .emit     (emit),
      .crc_next (crc_next)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (out_free) begin
         rsp_valid_in = s1_move && emit;
         rsp_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inject_enable_ff <= 1'b0;
         present_ff <= '0;
         byte_index_ff <= '0;
         frame_active_ff <= 1'b0;
         frame_targeted_ff <= 1'b0;
         block_base_ff <= '0;
         block_is_status_ff <= 1'b0;
         crc_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            inject_enable_ff <= csr_wr_data;
         end
         if (accept) begin
            present_ff <= present_in;
            byte_index_ff <= byte_index_in;
            frame_active_ff <= frame_active_in;
            frame_targeted_ff <= frame_targeted_in;
            block_base_ff <= block_base_in;
            block_is_status_ff <= block_is_status_in;
         end
         if (s1_move) begin
            crc_ff <= crc_next;
         end
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat = rsp_ff;

   `RDI_ASSERT_ALWAYS(a_index_bound, clock, reset, byte_index_ff <= rdi_pkg::FRAME_LAST)
   `RDI_ASSERT_IMPLIES(a_idle_frame, clock, reset, !frame_active_ff,
      (byte_index_ff == '0) && !frame_targeted_ff)
   `RDI_ASSERT_IMPLIES(a_end_on_crc, clock, reset, rsp_valid_ff && rsp_ff.frame_end,
      !frame_active_ff || (byte_index_ff < rdi_pkg::DATA_END))

endmodule

>>> tb/sv/response_defect_injector_core_test.sv
module response_defect_injector_core_test;

   localparam int SLOT_TOTAL = rdi_pkg::SLOT_COUNT_DEFAULT;
   localparam int FRAME_BEATS = 2 * rdi_pkg::BLOCK_REGS + 2;
   localparam int QUIET_LIMIT = 4000;

   typedef struct {
      bit cfg;
      bit cfg_on;
      rdi_pkg::req_type beat;
      int unsigned reps;
      bit typed;
      rdi_pkg::rsp_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;
   logic req_valid = 1'b0;
   logic rsp_stall = 1'b0;
   rdi_pkg::req_type req_beat = '0;
   logic req_stall;
   logic rsp_valid;
   rdi_pkg::rsp_type rsp_beat;

   // Shadow copy of the filter state.
   bit enable_m = 1'b0;
   bit present_m [SLOT_TOTAL] = '{default: 1'b0};
   logic [15:0] pos_m [SLOT_TOTAL] = '{default: '0};
   logic [2:0] stat_m [SLOT_TOTAL] = '{default: '0};
   logic [5:0] idx_m = '0;
   bit active_m = 1'b0;
   bit targeted_m = 1'b0;
   logic [5:0] base_m = '0;
   bit status_block_m = 1'b0;
   logic [15:0] crc_m = '0;

   rdi_pkg::rsp_type expected_bytes[$];
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned beats_sent = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;

   response_defect_injector_core uut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_beat(req_beat),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_beat(rsp_beat)
   );

   always #2 clock = ~clock;

   function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] c;
      c = acc ^ {d, 8'h00};
      repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ rdi_pkg::CRC_POLY) : {c[14:0], 1'b0};
      return c;
   endfunction

   function automatic void predict_beat(input rdi_pkg::req_type b, output bit emits,
                                        output rdi_pkg::rsp_type r);
      logic [15:0] word;
      logic [5:0] first;
      logic [5:0] s;
      bit hit;
      bit stat_sel;
      emits = 1'b0;
      r.out_byte = b.data_byte;
      r.byte_replaced = 1'b0;
      r.frame_end = 1'b0;
      case (b.cmd)
         rdi_pkg::CMD_HEADER: begin
            idx_m = '0;
            active_m = 1'b0;
            targeted_m = 1'b0;
            base_m = '0;
            status_block_m = 1'b0;
            if (b.hctrl[7] && b.hctrl[4:1] == rdi_pkg::FULL_BLOCK_COUNT) begin
               crc_m = crc16_next(crc16_next(rdi_pkg::CRC_INIT, b.hctrl), b.hadr);
               active_m = 1'b1;
               hit = 1'b0;
               stat_sel = 1'b0;
               first = '0;
               if (b.hadr >= rdi_pkg::POS_BASE_FIRST && b.hadr <= rdi_pkg::POS_BASE_LAST
                   && b.hadr[3:0] == 4'h0) begin
                  first = 6'(b.hadr - rdi_pkg::POS_BASE_FIRST);
                  hit = 1'b1;
               end else if (b.hadr >= rdi_pkg::STAT_BASE_FIRST
                            && b.hadr <= rdi_pkg::STAT_BASE_LAST
                            && b.hadr[3:0] == 4'h0) begin
                  first = 6'(b.hadr - rdi_pkg::STAT_BASE_FIRST);
                  hit = 1'b1;
                  stat_sel = 1'b1;
               end
               if (hit) begin
                  for (int k = 0; k < rdi_pkg::BLOCK_REGS; k++) begin
                     if (present_m[first + k]) begin
                        targeted_m = 1'b1;
                        base_m = first;
                        status_block_m = stat_sel;
                     end
                  end
               end
            end
         end
         rdi_pkg::CMD_WRITE_SLOT: begin
            present_m[b.slot] = 1'b1;
            pos_m[b.slot][15:9] = (b.pos_y > rdi_pkg::MAX_Y) ? rdi_pkg::MAX_Y[6:0]
                                                              : b.pos_y[6:0];
            pos_m[b.slot][8:0] = (b.pos_x > rdi_pkg::MAX_X) ? rdi_pkg::MAX_X : b.pos_x;
            stat_m[b.slot] = b.status;
         end
         rdi_pkg::CMD_CLEAR: begin
            present_m = '{default: 1'b0};
         end
         rdi_pkg::CMD_BYTE: begin
            emits = 1'b1;
            if (enable_m && active_m) begin
               if (idx_m < rdi_pkg::DATA_END) begin
                  if (targeted_m) begin
                     s = base_m + idx_m[5:1];
                     if (present_m[s]) begin
                        word = status_block_m ? 16'(stat_m[s]) : pos_m[s];
                        r.out_byte = idx_m[0] ? word[7:0] : word[15:8];
                        r.byte_replaced = 1'b1;
                     end
                  end
                  crc_m = crc16_next(crc_m, r.out_byte);
                  idx_m++;
               end else begin
                  if (targeted_m) begin
                     r.out_byte = (idx_m == rdi_pkg::DATA_END) ? crc_m[15:8] : crc_m[7:0];
                     r.byte_replaced = 1'b1;
                  end
                  idx_m++;
                  if (idx_m > rdi_pkg::FRAME_LAST) begin
                     r.frame_end = 1'b1;
                     idx_m = '0;
                     active_m = 1'b0;
                     targeted_m = 1'b0;
                  end
               end
            end
         end
      endcase
   endfunction

   function automatic rdi_pkg::req_type noise_beat();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(rdi_pkg::req_type)-1:0];
   endfunction

   function automatic rdi_pkg::req_type hdr_beat(input logic [7:0] h, input logic [7:0] a);
      rdi_pkg::req_type b;
      b = noise_beat();
      b.cmd = rdi_pkg::CMD_HEADER;
      b.hctrl = h;
      b.hadr = a;
      return b;
   endfunction

   function automatic rdi_pkg::req_type byte_beat(input logic [7:0] d);
      rdi_pkg::req_type b;
      b = noise_beat();
      b.cmd = rdi_pkg::CMD_BYTE;
      b.data_byte = d;
      return b;
   endfunction

   function automatic rdi_pkg::req_type slot_beat(input logic [5:0] s, input logic [8:0] x,
                                                  input logic [7:0] y, input logic [2:0] st);
      rdi_pkg::req_type b;
      b = noise_beat();
      b.cmd = rdi_pkg::CMD_WRITE_SLOT;
      b.slot = s;
      b.pos_x = x;
      b.pos_y = y;
      b.status = st;
      return b;
   endfunction

   function automatic rdi_pkg::req_type clear_beat();
      rdi_pkg::req_type b;
      b = noise_beat();
      b.cmd = rdi_pkg::CMD_CLEAR;
      return b;
   endfunction

   function automatic rdi_pkg::req_type random_slot_beat();
      return slot_beat(6'($urandom), 9'($urandom), 8'($urandom), 3'($urandom));
   endfunction

   function automatic logic [7:0] block_addr(input int unsigned k);
      if (k < 4) return 8'(rdi_pkg::POS_BASE_FIRST + 16 * k);
      return 8'(rdi_pkg::STAT_BASE_FIRST + 16 * (k - 4));
   endfunction

   function automatic plan_row_type row_beat(input rdi_pkg::req_type b, input int unsigned n);
      plan_row_type row;
      row.cfg = 1'b0;
      row.cfg_on = 1'b0;
      row.beat = b;
      row.reps = n;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic plan_row_type row_pass(input logic [7:0] d);
      plan_row_type row;
      row = row_beat(byte_beat(d), 1);
      row.typed = 1'b1;
      row.want.out_byte = d;
      return row;
   endfunction

   function automatic plan_row_type row_cfg(input bit on);
      plan_row_type row;
      row = row_beat('0, 0);
      row.cfg = 1'b1;
      row.cfg_on = on;
      return row;
   endfunction

   task automatic send_beat(input rdi_pkg::req_type b, input bit typed,
                            input rdi_pkg::rsp_type want);
      bit emits;
      rdi_pkg::rsp_type guess;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat <= b;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      predict_beat(b, emits, guess);
      if (emits) expected_bytes.push_back(typed ? want : guess);
   endtask

   task automatic send(input rdi_pkg::req_type b);
      send_beat(b, 1'b0, '0);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_enable(input bit on);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      enable_m = on;
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_episode();
      int unsigned pick;
      int unsigned len;
      int poke;
      logic [7:0] hc;
      logic [7:0] ha;
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         repeat ($urandom_range(1, 6)) send(random_slot_beat());
      end else if (pick < 18) begin
         send(clear_beat());
      end else if (pick < 78) begin
         // A well-formed read frame, now and then cut short or with a table change inside.
         hc = {1'b1, 2'($urandom), rdi_pkg::FULL_BLOCK_COUNT, 1'($urandom)};
         ha = ($urandom_range(0, 9) != 0) ? block_addr($urandom_range(0, 7)) : 8'($urandom);
         len = ($urandom_range(0, 9) != 0) ? FRAME_BEATS : $urandom_range(0, FRAME_BEATS - 1);
         poke = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, FRAME_BEATS - 1)) : -1;
         send(hdr_beat(hc, ha));
         for (int n = 0; n < len; n++) begin
            if (n == poke) send(($urandom_range(0, 2) == 0) ? clear_beat() : random_slot_beat());
            send(byte_beat(8'($urandom)));
         end
      end else if (pick < 92) begin
         send(hdr_beat(8'($urandom), 8'($urandom)));
         repeat ($urandom_range(0, 8)) send(byte_beat(8'($urandom)));
      end else begin
         repeat ($urandom_range(1, 8)) send(byte_beat(8'($urandom)));
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      rdi_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected response beat: out_byte %02h", rsp_beat.out_byte);
            mismatches++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_beat.out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_beat.out_byte);
               mismatches++;
            end
            if (rsp_beat.byte_replaced !== want.byte_replaced) begin
               $error("byte_replaced: expected %0b, got %0b", want.byte_replaced,
                      rsp_beat.byte_replaced);
               mismatches++;
            end
            if (rsp_beat.frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_beat.frame_end);
               mismatches++;
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      plan_row_type plan[$];
      int unsigned goal;
      plan.push_back(row_pass(8'hA5));
      plan.push_back(row_pass(8'h00));
      plan.push_back(row_beat(slot_beat(6'd0, 9'd511, 8'd255, 3'd7), 1));
      plan.push_back(row_beat(slot_beat(6'd63, 9'd0, 8'd0, 3'd0), 1));
      plan.push_back(row_beat(slot_beat(6'd17, 9'd319, 8'd79, 3'd5), 1));
      plan.push_back(row_beat(slot_beat(6'd50, 9'd200, 8'd60, 3'd2), 1));
      plan.push_back(row_beat(hdr_beat(8'h9E, 8'h70), 1));
      plan.push_back(row_pass(8'hFF));
      plan.push_back(row_cfg(1'b1));
      plan.push_back(row_beat(hdr_beat(8'h9E, 8'h70), 1));
      plan.push_back(row_beat(byte_beat(8'h3C), FRAME_BEATS));
      plan.push_back(row_beat(hdr_beat(8'h1E, 8'h70), 1));
      plan.push_back(row_pass(8'h11));
      plan.push_back(row_beat(hdr_beat(8'h9C, 8'h70), 1));
      plan.push_back(row_pass(8'h22));
      plan.push_back(row_beat(hdr_beat(8'h9E, 8'hB0), 1));
      plan.push_back(row_beat(byte_beat(8'h5A), 10));
      plan.push_back(row_beat(hdr_beat(8'h9E, 8'hF0), 1));
      plan.push_back(row_beat(byte_beat(8'h81), FRAME_BEATS));
      plan.push_back(row_beat(hdr_beat(8'h9E, 8'hA0), 1));
      plan.push_back(row_beat(byte_beat(8'h66), 20));
      plan.push_back(row_beat(clear_beat(), 1));
      plan.push_back(row_beat(byte_beat(8'h66), FRAME_BEATS - 20));
      plan.push_back(row_beat(hdr_beat(8'h9E, 8'h80), 1));
      plan.push_back(row_beat(slot_beat(6'd17, 9'd100, 8'd40, 3'd3), 1));
      plan.push_back(row_beat(byte_beat(8'h99), FRAME_BEATS));
      plan.push_back(row_beat(hdr_beat(8'h00, 8'h00), 1));
      plan.push_back(row_pass(8'h00));
      plan.push_back(row_beat(hdr_beat(8'hFF, 8'hFF), 1));
      plan.push_back(row_beat(byte_beat(8'hFF), FRAME_BEATS));
      plan.push_back(row_cfg(1'b0));
      plan.push_back(row_pass(8'h7E));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 21;
      rsp_idle_pct = 73;

      foreach (plan[i]) begin
         if (plan[i].cfg) begin
            set_enable(plan[i].cfg_on);
         end else begin
            repeat (plan[i].reps) send_beat(plan[i].beat, plan[i].typed, plan[i].want);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 21;
               rsp_idle_pct = 73;
            end
            1: begin
               send_idle_pct = 73;
               rsp_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            set_enable(seg != 1);
            goal = beats_sent + ((seg == 1) ? 40 : 110);
            while (beats_sent < goal) begin
               random_episode();
               if ($urandom_range(0, 19) == 0) drain_results();
            end
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/rdi_pkg.sv
rtl/core/rdi_ram.sv
rtl/core/rdi_rewrite.sv
rtl/core/response_defect_injector_core.sv
tb/sv/response_defect_injector_core_test.sv
